// ----- rtl/core/arf_pkg.sv -----
// shared types, constants and microcode program of the arma residual forecast filter
package arf_pkg;

   // default limits handed to the top level, and the forecast cap of the datapath
   localparam int MAX_AR_TAPS_DEF  = 8;
   localparam int MAX_MA_TAPS_DEF  = 8;
   localparam int MAX_FORECAST_DEF = 16;
   localparam int MAX_RESULTS      = 16;

   // number formats
   localparam int VALUE_W   = 32;
   localparam int COEF_W    = 16;
   localparam int FRAC_BITS = 12;
   localparam int PROD_W    = VALUE_W + COEF_W;
   localparam int SCALED_W  = PROD_W - FRAC_BITS;

   // coefficient register layout
   localparam int COEF_SLOTS    = 8;
   localparam int COEF_IDX_W    = 3;
   localparam int COEFS_PER_REG = 4;

   // register widths
   localparam int ORDER_W     = 4;
   localparam int STEPS_W     = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type REG_AR_ORDER       = 3'd0;
   localparam csr_index_type REG_MA_ORDER       = 3'd1;
   localparam csr_index_type REG_SERIES_MEAN    = 3'd2;
   localparam csr_index_type REG_FORECAST_STEPS = 3'd3;
   localparam csr_index_type REG_AR_COEFS_LOW   = 3'd4;
   localparam csr_index_type REG_AR_COEFS_HIGH  = 3'd5;
   localparam csr_index_type REG_MA_COEFS_LOW   = 3'd6;
   localparam csr_index_type REG_MA_COEFS_HIGH  = 3'd7;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [ORDER_W-1:0]                   ar_order;
      logic [ORDER_W-1:0]                   ma_order;
      logic signed [VALUE_W-1:0]            series_mean;
      logic [STEPS_W-1:0]                   forecast_steps;
      logic [COEF_SLOTS-1:0][COEF_W-1:0]    ar_coefs;
      logic [COEF_SLOTS-1:0][COEF_W-1:0]    ma_coefs;
   } cfg_type;

   // microcode fields
   typedef enum logic [1:0] {
      SEQ_JUMP   = 2'd0,
      SEQ_BRANCH = 2'd1,
      SEQ_HOLD   = 2'd2,
      SEQ_LOOP   = 2'd3
   } seq_mode_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_ACCEPT   = 3'd1,
      COND_KIND_END = 3'd2,
      COND_TAP_LEFT = 3'd3,
      COND_FC_DONE  = 3'd4,
      COND_OUT_FREE = 3'd5
   } cond_type;

   typedef enum logic [1:0] {
      ACC_HOLD   = 2'd0,
      ACC_SAMPLE = 2'd1,
      ACC_ZERO   = 2'd2
   } acc_op_type;

   typedef enum logic [1:0] {
      MAC_NONE = 2'd0,
      MAC_AR   = 2'd1,
      MAC_MA   = 2'd2
   } mac_op_type;

   typedef enum logic [1:0] {
      EMIT_NONE = 2'd0,
      EMIT_RES  = 2'd1,
      EMIT_FC   = 2'd2
   } emit_op_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   // program addresses
   localparam step_type STEP_IDLE     = 4'd0;
   localparam step_type STEP_DISPATCH = 4'd1;
   localparam step_type STEP_AR       = 4'd2;
   localparam step_type STEP_MA       = 4'd3;
   localparam step_type STEP_RES      = 4'd4;
   localparam step_type STEP_FC_CHECK = 4'd5;
   localparam step_type STEP_FC_AR    = 4'd6;
   localparam step_type STEP_FC_MA    = 4'd7;
   localparam step_type STEP_FC_EMIT  = 4'd8;
   localparam step_type STEP_CLEAR    = 4'd9;
   localparam step_type STEP_LAST     = STEP_CLEAR;

   typedef struct packed {
      seq_mode_type seq;
      cond_type     cond;
      step_type     target;
      logic         take;
      acc_op_type   acc_op;
      mac_op_type   mac_op;
      logic         mac_neg;
      logic         ma_shift;
      emit_op_type  emit_op;
      logic         clear_hist;
   } ctrl_word_type;

   // datapath conditions seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic kind_end;
      logic tap_left;
      logic fc_done;
      logic out_free;
   } status_type;

   // control store
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.seq = SEQ_HOLD; w.cond = COND_ACCEPT; w.target = STEP_DISPATCH;
            w.take = 1'b1;
         end
         STEP_DISPATCH: begin
            w.seq = SEQ_BRANCH; w.cond = COND_KIND_END; w.target = STEP_FC_CHECK;
            w.acc_op = ACC_SAMPLE;
         end
         STEP_AR: begin
            w.seq = SEQ_LOOP; w.cond = COND_TAP_LEFT;
            w.mac_op = MAC_AR; w.mac_neg = 1'b1;
         end
         STEP_MA: begin
            w.seq = SEQ_LOOP; w.cond = COND_TAP_LEFT;
            w.mac_op = MAC_MA;
         end
         STEP_RES: begin
            w.seq = SEQ_HOLD; w.cond = COND_OUT_FREE; w.target = STEP_IDLE;
            w.emit_op = EMIT_RES;
         end
         STEP_FC_CHECK: begin
            w.seq = SEQ_BRANCH; w.cond = COND_FC_DONE; w.target = STEP_CLEAR;
            w.acc_op = ACC_ZERO;
         end
         STEP_FC_AR: begin
            w.seq = SEQ_LOOP; w.cond = COND_TAP_LEFT;
            w.mac_op = MAC_AR;
         end
         STEP_FC_MA: begin
            w.seq = SEQ_LOOP; w.cond = COND_TAP_LEFT;
            w.mac_op = MAC_MA; w.mac_neg = 1'b1; w.ma_shift = 1'b1;
         end
         STEP_FC_EMIT: begin
            w.seq = SEQ_HOLD; w.cond = COND_OUT_FREE; w.target = STEP_FC_CHECK;
            w.emit_op = EMIT_FC;
         end
         STEP_CLEAR: begin
            w.seq = SEQ_JUMP; w.cond = COND_ALWAYS; w.target = STEP_IDLE;
            w.clear_hist = 1'b1;
         end
         default: begin
            w.seq = SEQ_JUMP; w.cond = COND_ALWAYS; w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/arf_channels.sv -----
// valid/ready channel interfaces for requests, results and register writes

interface arf_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [arf_pkg::VALUE_W-1:0]  sample_value;

   modport source (output valid, output kind, output sample_value, input ready);
   modport sink   (input valid, input kind, input sample_value, output ready);
endinterface

interface arf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                result_kind;
   logic signed [arf_pkg::VALUE_W-1:0]  result_value;
   logic                                last;

   modport source (output valid, output result_kind, output result_value, output last,
                   input ready);
   modport sink   (input valid, input result_kind, input result_value, input last,
                   output ready);
endinterface

interface arf_csr_if;
   logic                                valid;
   logic                                ready;
   arf_pkg::csr_index_type              index;
   logic [arf_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/arma_residual_forecast_filter_unit.sv -----
// top level of the arma residual forecast filter
// a sample runs dispatch, an ar walk over p taps, an ma walk over q taps and the residual
//   emit, p and q the orders in use; the next item is taken in the cycle after the emit
// an end item runs per forecast i a check, p ar taps, max(q - i, 0) ma taps and an emit
// one shared multiply-accumulate walks the taps one per cycle under the microcode program
// reset: sequencer to idle, registers to their reset values, histories empty
module arma_residual_forecast_filter_unit #(
   parameter int MAX_AR_TAPS  = arf_pkg::MAX_AR_TAPS_DEF,
   parameter int MAX_MA_TAPS  = arf_pkg::MAX_MA_TAPS_DEF,
   parameter int MAX_FORECAST = arf_pkg::MAX_FORECAST_DEF
) (
   input  logic       clock,
   input  logic       reset,
   arf_req_if.sink    req_chan,
   arf_rsp_if.source  rsp_chan,
   arf_csr_if.sink    csr_chan
);

   arf_pkg::cfg_type       cfg;
   arf_pkg::ctrl_word_type ctrl;
   arf_pkg::status_type    status;

   // configuration registers
   arf_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .csr_ready (csr_chan.ready),
      .cfg       (cfg)
   );

   // microcode sequencer
   arf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // datapath
   arf_datapath #(
      .MAX_AR_TAPS  (MAX_AR_TAPS),
      .MAX_MA_TAPS  (MAX_MA_TAPS),
      .MAX_FORECAST (MAX_FORECAST)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .cfg              (cfg),
      .req_valid        (req_chan.valid),
      .req_kind         (req_chan.kind),
      .req_sample_value (req_chan.sample_value),
      .req_ready        (req_chan.ready),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_result_kind  (rsp_chan.result_kind),
      .rsp_result_value (rsp_chan.result_value),
      .rsp_last         (rsp_chan.last),
      .status           (status)
   );

endmodule

// ----- rtl/core/arf_csr_regs.sv -----
// configuration register file with write decode
module arf_csr_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  arf_pkg::csr_index_type         csr_index,
   input  logic [arf_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                           csr_ready,
   output arf_pkg::cfg_type               cfg
);

   // reset values: one ar tap, everything else zero
   localparam arf_pkg::cfg_type CFG_RESET = arf_pkg::cfg_type'({
      arf_pkg::ORDER_W'(1),
      {($bits(arf_pkg::cfg_type) - arf_pkg::ORDER_W){1'b0}}
   });

   arf_pkg::cfg_type cfg_ff;
   arf_pkg::cfg_type cfg_in;
   logic             write_en;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign write_en  = csr_valid;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index)
            arf_pkg::REG_AR_ORDER:
               cfg_in.ar_order = csr_data[arf_pkg::ORDER_W-1:0];
            arf_pkg::REG_MA_ORDER:
               cfg_in.ma_order = csr_data[arf_pkg::ORDER_W-1:0];
            arf_pkg::REG_SERIES_MEAN:
               cfg_in.series_mean = csr_data[arf_pkg::VALUE_W-1:0];
            arf_pkg::REG_FORECAST_STEPS:
               cfg_in.forecast_steps = csr_data[arf_pkg::STEPS_W-1:0];
            arf_pkg::REG_AR_COEFS_LOW:
               cfg_in.ar_coefs[arf_pkg::COEFS_PER_REG-1:0] = csr_data;
            arf_pkg::REG_AR_COEFS_HIGH:
               cfg_in.ar_coefs[arf_pkg::COEF_SLOTS-1:arf_pkg::COEFS_PER_REG] = csr_data;
            arf_pkg::REG_MA_COEFS_LOW:
               cfg_in.ma_coefs[arf_pkg::COEFS_PER_REG-1:0] = csr_data;
            arf_pkg::REG_MA_COEFS_HIGH:
               cfg_in.ma_coefs[arf_pkg::COEF_SLOTS-1:arf_pkg::COEFS_PER_REG] = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/arf_sequencer.sv -----
// microcode sequencer: program counter, control store lookup and jumps
module arf_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  arf_pkg::status_type    status,
   output arf_pkg::ctrl_word_type ctrl
);

   arf_pkg::step_type pc_ff;
   arf_pkg::step_type pc_in;
   logic              cond_met;

   // fetch the control word of the current step
   assign ctrl = arf_pkg::ucode_rom(pc_ff);

   // condition select
   always_comb begin
      unique case (ctrl.cond)
         arf_pkg::COND_ALWAYS:   cond_met = 1'b1;
         arf_pkg::COND_ACCEPT:   cond_met = status.req_valid;
         arf_pkg::COND_KIND_END: cond_met = status.kind_end;
         arf_pkg::COND_TAP_LEFT: cond_met = status.tap_left;
         arf_pkg::COND_FC_DONE:  cond_met = status.fc_done;
         arf_pkg::COND_OUT_FREE: cond_met = status.out_free;
         default:                cond_met = 1'b1;
      endcase
   end

   // next step
   always_comb begin
      unique case (ctrl.seq)
         arf_pkg::SEQ_JUMP:   pc_in = ctrl.target;
         arf_pkg::SEQ_BRANCH: pc_in = cond_met ? ctrl.target : pc_ff + arf_pkg::STEP_W'(1);
         arf_pkg::SEQ_HOLD:   pc_in = cond_met ? ctrl.target : pc_ff;
         arf_pkg::SEQ_LOOP:   pc_in = cond_met ? pc_ff : pc_ff + arf_pkg::STEP_W'(1);
         default:             pc_in = arf_pkg::STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= arf_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // program counter stays inside the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= arf_pkg::STEP_LAST)
      else $error("sequencer left the program");

   // a transfer in the idle step always goes to dispatch
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == arf_pkg::STEP_IDLE && status.req_valid) |=>
      (pc_ff == arf_pkg::STEP_DISPATCH))
      else $error("accepted item not dispatched");

endmodule

// ----- rtl/core/arf_datapath.sv -----
// datapath: histories, shared multiply-accumulate, saturation and result register
module arf_datapath #(
   parameter int MAX_AR_TAPS  = arf_pkg::MAX_AR_TAPS_DEF,
   parameter int MAX_MA_TAPS  = arf_pkg::MAX_MA_TAPS_DEF,
   parameter int MAX_FORECAST = arf_pkg::MAX_FORECAST_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  arf_pkg::ctrl_word_type              ctrl,
   input  arf_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   input  logic                                req_kind,
   input  logic signed [arf_pkg::VALUE_W-1:0]  req_sample_value,
   output logic                                req_ready,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_result_kind,
   output logic signed [arf_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic                                rsp_last,
   output arf_pkg::status_type                 status
);

   localparam int VW       = arf_pkg::VALUE_W;
   localparam int TAP_MAX  = (MAX_AR_TAPS > MAX_MA_TAPS) ? MAX_AR_TAPS : MAX_MA_TAPS;
   localparam int FC_LIMIT = (MAX_FORECAST < arf_pkg::MAX_RESULTS) ?
                             MAX_FORECAST : arf_pkg::MAX_RESULTS;
   localparam int TAP_CALC = $clog2(TAP_MAX + FC_LIMIT + 1);
   localparam int TAP_W    = (TAP_CALC > 5) ? TAP_CALC : 5;
   localparam int FC_W     = $clog2(FC_LIMIT + 1);
   localparam int AR_SEEN_W = $clog2(MAX_AR_TAPS + 1);
   localparam int MA_SEEN_W = $clog2(MAX_MA_TAPS + 1);
   localparam int AR_IDX_W = (MAX_AR_TAPS > 1) ? $clog2(MAX_AR_TAPS) : 1;
   localparam int MA_IDX_W = (MAX_MA_TAPS > 1) ? $clog2(MAX_MA_TAPS) : 1;
   localparam int SW       = arf_pkg::SCALED_W;
   localparam int ACC_W    = SW + $clog2(MAX_AR_TAPS + MAX_MA_TAPS + 1) + 1;

   // item registers
   logic                   kind_ff, kind_in;
   logic signed [VW-1:0]   sample_ff, sample_in;

   // histories, lag 1 first
   logic signed [VW-1:0]   sample_hist_ff [MAX_AR_TAPS];
   logic signed [VW-1:0]   sample_hist_in [MAX_AR_TAPS];
   logic signed [VW-1:0]   resid_hist_ff  [MAX_MA_TAPS];
   logic signed [VW-1:0]   resid_hist_in  [MAX_MA_TAPS];
   logic [AR_SEEN_W-1:0]   ar_seen_ff, ar_seen_in;
   logic [MA_SEEN_W-1:0]   ma_seen_ff, ma_seen_in;

   // loop counters
   logic [TAP_W-1:0]       tap_cnt_ff, tap_cnt_in;
   logic [FC_W-1:0]        fc_cnt_ff, fc_cnt_in;

   // multiply-accumulate
   logic signed [SW-1:0]    prod_ff, prod_in;
   logic                    prod_vld_ff, prod_vld_in;
   logic                    prod_neg_ff, prod_neg_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic signed [VW-1:0]   rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   out_free;
   logic                   emit_fire;
   logic                   tap_left;
   logic [TAP_W-1:0]       ar_ord_ext, ma_ord_ext;
   logic [TAP_W-1:0]       p_lim, q_lim;
   logic [FC_W-1:0]        n_lim;
   logic [TAP_W-1:0]       tap_idx;
   logic signed [VW-1:0]   ar_lag, ma_lag, mul_a;
   logic signed [arf_pkg::COEF_W-1:0] ar_coef, ma_coef, mul_b;
   logic signed [arf_pkg::PROD_W-1:0] product;
   logic signed [ACC_W-1:0] prod_ext, sample_ext;
   logic [ACC_W-VW:0]      acc_top;
   logic signed [VW-1:0]   sat_value;

   // handshake
   assign req_ready = ctrl.take;
   assign accept    = req_valid && ctrl.take;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_fire = (ctrl.emit_op != arf_pkg::EMIT_NONE) && out_free;

   // orders and forecast count limited to the hardware
   assign ar_ord_ext = TAP_W'(cfg.ar_order);
   assign ma_ord_ext = TAP_W'(cfg.ma_order);
   assign p_lim = (ar_ord_ext > TAP_W'(MAX_AR_TAPS)) ? TAP_W'(MAX_AR_TAPS) : ar_ord_ext;
   assign q_lim = (ma_ord_ext > TAP_W'(MAX_MA_TAPS)) ? TAP_W'(MAX_MA_TAPS) : ma_ord_ext;
   assign n_lim = (cfg.forecast_steps > arf_pkg::STEPS_W'(FC_LIMIT)) ?
                  FC_W'(FC_LIMIT) : FC_W'(cfg.forecast_steps);

   // tap walk; forecast ma taps start at the forecast index
   assign tap_idx = tap_cnt_ff + (ctrl.ma_shift ? TAP_W'(fc_cnt_ff) : '0);

   always_comb begin
      unique case (ctrl.mac_op)
         arf_pkg::MAC_AR: tap_left = tap_cnt_ff < p_lim;
         arf_pkg::MAC_MA: tap_left = tap_idx < q_lim;
         default:         tap_left = 1'b0;
      endcase
   end

   // operand select: missing ar lags read as the mean, missing ma lags as zero
   assign ar_lag = (tap_cnt_ff < TAP_W'(ar_seen_ff)) ?
                   sample_hist_ff[tap_cnt_ff[AR_IDX_W-1:0]] : cfg.series_mean;
   assign ma_lag = (tap_cnt_ff < TAP_W'(ma_seen_ff)) ?
                   resid_hist_ff[tap_cnt_ff[MA_IDX_W-1:0]] : '0;
   assign ar_coef = (tap_cnt_ff < TAP_W'(arf_pkg::COEF_SLOTS)) ?
                    cfg.ar_coefs[tap_cnt_ff[arf_pkg::COEF_IDX_W-1:0]] : '0;
   assign ma_coef = (tap_idx < TAP_W'(arf_pkg::COEF_SLOTS)) ?
                    cfg.ma_coefs[tap_idx[arf_pkg::COEF_IDX_W-1:0]] : '0;
   assign mul_a   = (ctrl.mac_op == arf_pkg::MAC_MA) ? ma_lag : ar_lag;
   assign mul_b   = (ctrl.mac_op == arf_pkg::MAC_MA) ? ma_coef : ar_coef;

   // product with a q4.12 coefficient floored back to the value scale by dropping fraction bits
   assign product     = mul_a * mul_b;
   assign prod_in     = product[arf_pkg::PROD_W-1:arf_pkg::FRAC_BITS];
   assign prod_vld_in = tap_left;
   assign prod_neg_in = ctrl.mac_neg;
   assign tap_cnt_in  = tap_left ? tap_cnt_ff + TAP_W'(1) : '0;

   // accumulator
   assign prod_ext   = {{(ACC_W-SW){prod_ff[SW-1]}}, prod_ff};
   assign sample_ext = {{(ACC_W-VW){sample_ff[VW-1]}}, sample_ff};

   always_comb begin
      unique case (ctrl.acc_op)
         arf_pkg::ACC_SAMPLE: acc_in = sample_ext;
         arf_pkg::ACC_ZERO:   acc_in = '0;
         default: begin
            if (prod_vld_ff) begin
               acc_in = prod_neg_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
            end else begin
               acc_in = acc_ff;
            end
         end
      endcase
   end

   // saturate to 32 bits
   assign acc_top = acc_ff[ACC_W-1:VW-1];
   always_comb begin
      if ((&acc_top) || !(|acc_top)) begin
         sat_value = acc_ff[VW-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         sat_value = {1'b1, {(VW-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(VW-1){1'b1}}};
      end
   end

   // item capture and forecast counter
   assign kind_in   = accept ? req_kind : kind_ff;
   assign sample_in = accept ? req_sample_value : sample_ff;

   always_comb begin
      if (accept) begin
         fc_cnt_in = '0;
      end else if (emit_fire && ctrl.emit_op == arf_pkg::EMIT_FC) begin
         fc_cnt_in = fc_cnt_ff + FC_W'(1);
      end else begin
         fc_cnt_in = fc_cnt_ff;
      end
   end

   // history update: residual pushes sample and residual, forecast pushes itself
   always_comb begin
      sample_hist_in = sample_hist_ff;
      resid_hist_in  = resid_hist_ff;
      ar_seen_in     = ar_seen_ff;
      ma_seen_in     = ma_seen_ff;
      if (ctrl.clear_hist) begin
         ar_seen_in = '0;
         ma_seen_in = '0;
      end else if (emit_fire) begin
         for (int i = MAX_AR_TAPS - 1; i > 0; i--) begin
            sample_hist_in[i] = sample_hist_ff[i-1];
         end
         if (ar_seen_ff < AR_SEEN_W'(MAX_AR_TAPS)) begin
            ar_seen_in = ar_seen_ff + AR_SEEN_W'(1);
         end
         if (ctrl.emit_op == arf_pkg::EMIT_RES) begin
            sample_hist_in[0] = sample_ff;
            for (int i = MAX_MA_TAPS - 1; i > 0; i--) begin
               resid_hist_in[i] = resid_hist_ff[i-1];
            end
            resid_hist_in[0] = sat_value;
            if (ma_seen_ff < MA_SEEN_W'(MAX_MA_TAPS)) begin
               ma_seen_in = ma_seen_ff + MA_SEEN_W'(1);
            end
         end else begin
            sample_hist_in[0] = sat_value;
         end
      end
   end

   // result register, freed by a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = (ctrl.emit_op == arf_pkg::EMIT_FC);
         rsp_value_in = sat_value;
         rsp_last_in  = (ctrl.emit_op == arf_pkg::EMIT_RES) ||
                        ({1'b0, fc_cnt_ff} + (FC_W+1)'(1) == {1'b0, n_lim});
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ar_seen_ff   <= '0;
         ma_seen_ff   <= '0;
         tap_cnt_ff   <= '0;
         fc_cnt_ff    <= '0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ar_seen_ff   <= ar_seen_in;
         ma_seen_ff   <= ma_seen_in;
         tap_cnt_ff   <= tap_cnt_in;
         fc_cnt_ff    <= fc_cnt_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      sample_ff      <= sample_in;
      sample_hist_ff <= sample_hist_in;
      resid_hist_ff  <= resid_hist_in;
      prod_ff        <= prod_in;
      prod_neg_ff    <= prod_neg_in;
      acc_ff         <= acc_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

   // conditions for the sequencer
   always_comb begin
      status.req_valid = req_valid;
      status.kind_end  = kind_ff;
      status.tap_left  = tap_left;
      status.fc_done   = fc_cnt_ff >= n_lim;
      status.out_free  = out_free;
   end

   // history fill counts never pass the history depth
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      (ar_seen_ff <= AR_SEEN_W'(MAX_AR_TAPS)) && (ma_seen_ff <= MA_SEEN_W'(MAX_MA_TAPS)))
      else $error("history fill count out of range");

   // a result is only taken once the last product has been summed
   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> !prod_vld_ff)
      else $error("result emitted with a product still pending");

   // forecast ma taps are walked only for forecasts that are due
   a_fc_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.ma_shift && tap_left) |-> (fc_cnt_ff < n_lim))
      else $error("forecast index beyond the forecast count");

endmodule
